// ===== rtl/tmts_pkg.sv =====
// Package for the train mode transition selector: mode codes, transition
// table and information table lookups. No dependencies.
package tmts_pkg;

  localparam int NumConditions = 78;
  localparam int NumInfoItems  = 53;
  localparam int NumModes      = 17;
  localparam int NumTrans      = 125;
  localparam int MaxConds      = 9;
  localparam int InfoRows      = 53;
  localparam logic [6:0] NoCond = 7'd78;
  localparam logic [3:0] NoPrio = 4'd10;

  typedef enum logic [4:0] {
    M_NP = 5'd0, M_SB = 5'd1, M_PS = 5'd2, M_SH = 5'd3, M_FS = 5'd4,
    M_LS = 5'd5, M_SR = 5'd6, M_OS = 5'd7, M_SL = 5'd8, M_NL = 5'd9,
    M_UN = 5'd10, M_TR = 5'd11, M_PT = 5'd12, M_SF = 5'd13, M_IS = 5'd14,
    M_SN = 5'd15, M_RV = 5'd16
  } mode_e;

  typedef struct packed {
    logic [4:0] src;
    logic [4:0] dst;
    logic [3:0] prio;
    logic [3:0] n;
    logic [MaxConds*7-1:0] c;
  } trans_t;

  function automatic logic [MaxConds*7-1:0] cl(input int a, input int b, input int c,
                                              input int d, input int e, input int f,
                                              input int g, input int h, input int i);
    cl = {7'(i), 7'(h), 7'(g), 7'(f), 7'(e), 7'(d), 7'(c), 7'(b), 7'(a)};
  endfunction

  function automatic trans_t tr(input mode_e s, input mode_e d, input int p, input int n,
                                input int a, input int b = 0, input int c = 0,
                                input int e = 0, input int f = 0, input int g = 0,
                                input int h = 0, input int i = 0, input int j = 0);
    tr.src = s;
    tr.dst = d;
    tr.prio = 4'(p);
    tr.n = 4'(n);
    tr.c = cl(a, b, c, e, f, g, h, i, j);
  endfunction

  function automatic trans_t trans_at(input int t);
    trans_t r;
    r = '0;
    case (t)
      0: r = tr(M_SB,M_SR,7,2,8,37); 1: r = tr(M_FS,M_SR,6,1,37);
      2: r = tr(M_LS,M_SR,6,1,37); 3: r = tr(M_OS,M_SR,6,1,37);
      4: r = tr(M_PT,M_SR,5,2,8,37); 5: r = tr(M_UN,M_SR,4,2,44,45);
      6: r = tr(M_SN,M_SR,4,2,44,45);
      7: r = tr(M_SB,M_FS,7,1,10); 8: r = tr(M_LS,M_FS,6,2,31,32);
      9: r = tr(M_SR,M_FS,6,2,31,32); 10: r = tr(M_OS,M_FS,6,2,31,32);
      11: r = tr(M_UN,M_FS,7,1,25); 12: r = tr(M_PT,M_FS,5,1,31);
      13: r = tr(M_SN,M_FS,7,1,25);
      14: r = tr(M_SB,M_TR,4,1,20); 15: r = tr(M_SH,M_TR,4,3,49,52,65);
      16: r = tr(M_FS,M_TR,4,9,12,16,17,18,20,41,65,66,69);
      17: r = tr(M_LS,M_TR,4,9,12,16,17,18,20,41,65,66,69);
      18: r = tr(M_SR,M_TR,4,7,18,20,36,42,43,54,65);
      19: r = tr(M_OS,M_TR,4,9,12,16,17,18,20,41,65,66,69);
      20: r = tr(M_UN,M_TR,5,3,20,39,67); 21: r = tr(M_SN,M_TR,5,5,20,35,38,39,67);
      22: r = tr(M_TR,M_PT,4,1,7);
      23: r = tr(M_SB,M_UN,7,1,60); 24: r = tr(M_FS,M_UN,6,1,21);
      25: r = tr(M_LS,M_UN,6,1,21); 26: r = tr(M_SR,M_UN,6,1,21);
      27: r = tr(M_OS,M_UN,6,1,21); 28: r = tr(M_TR,M_UN,4,1,62);
      29: r = tr(M_SN,M_UN,7,1,21);
      30: r = tr(M_SB,M_SH,7,3,5,6,50); 31: r = tr(M_PS,M_SH,4,1,23);
      32: r = tr(M_FS,M_SH,6,4,5,6,50,51); 33: r = tr(M_LS,M_SH,6,4,5,6,50,51);
      34: r = tr(M_SR,M_SH,6,3,5,6,51); 35: r = tr(M_OS,M_SH,6,4,5,6,50,51);
      36: r = tr(M_UN,M_SH,7,2,5,61); 37: r = tr(M_TR,M_SH,4,1,68);
      38: r = tr(M_PT,M_SH,5,3,5,6,50); 39: r = tr(M_SN,M_SH,7,2,5,61);
      40: r = tr(M_NP,M_SB,2,1,4); 41: r = tr(M_PS,M_SB,4,1,22);
      42: r = tr(M_SH,M_SB,5,3,19,27,30); 43: r = tr(M_FS,M_SB,5,1,28);
      44: r = tr(M_LS,M_SB,5,1,28); 45: r = tr(M_SR,M_SB,5,1,28);
      46: r = tr(M_OS,M_SB,5,1,28); 47: r = tr(M_SL,M_SB,3,2,2,3);
      48: r = tr(M_NL,M_SB,3,2,28,47); 49: r = tr(M_UN,M_SB,6,1,28);
      50: r = tr(M_PT,M_SB,4,1,28); 51: r = tr(M_SN,M_SB,6,1,28);
      52: r = tr(M_RV,M_SB,4,1,28);
      53: r = tr(M_SB,M_OS,7,1,15); 54: r = tr(M_FS,M_OS,6,2,15,40);
      55: r = tr(M_LS,M_OS,6,2,15,73); 56: r = tr(M_SR,M_OS,6,1,40);
      57: r = tr(M_UN,M_OS,7,1,34); 58: r = tr(M_PT,M_OS,5,1,15);
      59: r = tr(M_SN,M_OS,7,1,34);
      60: r = tr(M_SB,M_SL,5,1,14); 61: r = tr(M_PS,M_SL,4,1,14);
      62: r = tr(M_FS,M_UN,6,1,59); 63: r = tr(M_LS,M_UN,6,1,59);
      64: r = tr(M_OS,M_UN,6,1,59);
      65: r = tr(M_SB,M_SN,7,1,58); 66: r = tr(M_FS,M_SN,6,1,56);
      67: r = tr(M_LS,M_SN,6,1,56); 68: r = tr(M_SR,M_SN,6,1,56);
      69: r = tr(M_OS,M_SN,6,1,56); 70: r = tr(M_UN,M_SN,7,1,56);
      71: r = tr(M_TR,M_SN,4,1,63);
      72: r = tr(M_SB,M_LS,7,1,70); 73: r = tr(M_FS,M_LS,6,2,70,72);
      74: r = tr(M_SR,M_LS,6,1,72); 75: r = tr(M_OS,M_LS,6,2,70,74);
      76: r = tr(M_UN,M_LS,7,1,71); 77: r = tr(M_PT,M_LS,5,1,70);
      78: r = tr(M_SN,M_LS,7,1,71);
      79: r = tr(M_NP,M_IS,1,1,1); 80: r = tr(M_SB,M_IS,1,1,1);
      81: r = tr(M_PS,M_IS,1,1,1); 82: r = tr(M_SH,M_IS,1,1,1);
      83: r = tr(M_FS,M_IS,1,1,1); 84: r = tr(M_LS,M_IS,1,1,1);
      85: r = tr(M_SR,M_IS,1,1,1); 86: r = tr(M_OS,M_IS,1,1,1);
      87: r = tr(M_SL,M_IS,1,1,1); 88: r = tr(M_NL,M_IS,1,1,1);
      89: r = tr(M_UN,M_IS,1,1,1); 90: r = tr(M_TR,M_IS,1,1,1);
      91: r = tr(M_PT,M_IS,1,1,1); 92: r = tr(M_SF,M_IS,1,1,1);
      93: r = tr(M_SN,M_IS,1,1,1); 94: r = tr(M_RV,M_IS,1,1,1);
      95: r = tr(M_SB,M_NL,6,1,46); 96: r = tr(M_SH,M_NL,5,1,46);
      97: r = tr(M_FS,M_NL,6,1,46); 98: r = tr(M_LS,M_NL,6,1,46);
      99: r = tr(M_SR,M_NL,6,1,46); 100: r = tr(M_OS,M_NL,6,1,46);
      101: r = tr(M_IS,M_SB,1,1,75);
      102: r = tr(M_NP,M_SF,1,1,76); 103: r = tr(M_SB,M_SF,1,1,76);
      104: r = tr(M_PS,M_SF,1,1,76); 105: r = tr(M_SH,M_SF,1,1,76);
      106: r = tr(M_FS,M_SF,1,1,76); 107: r = tr(M_LS,M_SF,1,1,76);
      108: r = tr(M_SR,M_SF,1,1,76); 109: r = tr(M_OS,M_SF,1,1,76);
      110: r = tr(M_SL,M_SF,1,1,76); 111: r = tr(M_NL,M_SF,1,1,76);
      112: r = tr(M_UN,M_SF,1,1,76); 113: r = tr(M_TR,M_SF,1,1,76);
      114: r = tr(M_PT,M_SF,1,1,76); 115: r = tr(M_SF,M_SF,1,1,76);
      116: r = tr(M_SN,M_SF,1,1,76); 117: r = tr(M_RV,M_SF,1,1,76);
      118: r = tr(M_SF,M_SB,1,1,77);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Row strings, column order NP SB PS SH FS LS SR OS SL NL UN TR PT SF IS SN RV.
  function automatic logic [NumModes*8-1:0] info_row(input int k);
    case (k)
      0: return "UUUUUUUUUUUUUNNUU"; 1: return "DUUUUUUUUUUUUNNUU";
      2, 3, 4, 5, 6, 11, 18, 19, 25, 26, 45, 46: return
        (k == 11) ? "DDUUUUDUDDDDUNNDD" : "DDDDUUDUDDDDUNNDD";
      7, 8: return "DDDDUUDUDDUUUNNUD"; 9: return "DXUYUUDUYZDUUNNDD";
      10: return "DDUUUUUUDUUUUNNUU"; 12, 13, 47: return "DUUUUUUUUUUUUNNUU";
      14: return "DDDDDDUDDDDDUNNDD"; 15: return "DDDDUUUUDDUUUNNDD";
      16, 32, 33: return "DDDDUUDUDDDUUNNDD"; 17: return "DDDDUUUUDDUUUNNDD";
      20: return "RRRRUUUURRUUUNNRU"; 21: return "RRRRUUUURRUUUNNUU";
      22, 23: return "DDDDUUUUDDUUUNNDU"; 24: return "DUDDUUUUDUUUUNNDD";
      27: return "DDDDUUDDDDDDUNNDD"; 28, 34, 36, 37, 40: return "TUUUUUUUUUUUUNNUU";
      29: return "RRRRUURURURUUNNRR"; 30: return "RRRRUURRRRRRRNNRR";
      31: return "RRRRUURURUUUUNNUR"; 35: return "DTUTUUUUUUUUUNNUU";
      38, 41: return "DTUUUUUUDUUUUNNUU"; 42, 43: return "DDDDUUDUDDDDUNNDU";
      44: return "DDDDDDUUDDDDUNNDD"; 52: return "DDDDDUDDDDUDUNNDD";
      default: return "UUUUUUUUUUUUUNNUU";
    endcase
  endfunction

  function automatic logic [7:0] info_code(input int k, input logic [4:0] m);
    logic [NumModes*8-1:0] row;
    row = info_row(k);
    return row[(NumModes - 1 - int'(m)) * 8 +: 8];
  endfunction

endpackage

// ===== rtl/tmts_select.sv =====
// Transition selection: picks the winning transition out of the current mode.
// Depends on tmts_pkg.
module tmts_select import tmts_pkg::*; #(
  parameter int NUM_CONDITIONS = NumConditions
) (
  input  logic [4:0]                cur_mode_i,
  input  logic [NUM_CONDITIONS-1:0] cond_i,
  output logic [4:0]                dst_o,
  output logic [6:0]                win_o
);
  logic [4:0] prev;
  always_comb begin
    logic [3:0] best;
    logic [6:0] low;
    logic [6:0] cc;
    trans_t t;
    prev = (cur_mode_i >= 5'(NumModes)) ? M_NP : cur_mode_i;
    best = NoPrio;
    dst_o = prev;
    win_o = NoCond;
    for (int i = 0; i < NumTrans; i++) begin
      t = trans_at(i);
      low = NoCond;
      for (int j = MaxConds - 1; j >= 0; j--) begin
        cc = t.c[j*7 +: 7];
        if (4'(j) < t.n && int'(cc) < NUM_CONDITIONS && cond_i[cc]) low = cc;
      end
      if (t.src == prev && t.prio < best && low != NoCond) begin
        best = t.prio;
        dst_o = t.dst;
        win_o = low;
      end
    end
  end
endmodule

// ===== rtl/tmts_info.sv =====
// Information table lookup: delete and invalidate masks for the entered mode.
// Depends on tmts_pkg.
module tmts_info import tmts_pkg::*; #(
  parameter int NUM_INFO_ITEMS = NumInfoItems
) (
  input  logic [4:0]                prev_i,
  input  logic [4:0]                dst_i,
  output logic [NUM_INFO_ITEMS-1:0] del_o,
  output logic [NUM_INFO_ITEMS-1:0] inv_o
);
  always_comb begin
    logic [7:0] c;
    del_o = '0;
    inv_o = '0;
    for (int k = 0; k < NUM_INFO_ITEMS; k++) begin
      if (k < InfoRows) begin
        c = info_code(k, dst_i);
        case (c)
          "D", "R": del_o[k] = 1'b1;
          "X":      del_o[k] = (prev_i != M_SH) && (prev_i != M_PS);
          "Y":      del_o[k] = (prev_i != M_PS);
          "Z":      del_o[k] = (prev_i != M_SH);
          "T":      inv_o[k] = 1'b1;
          default:  ;
        endcase
      end
    end
  end
endmodule

// ===== rtl/train_mode_transition_selector.sv =====
// Train mode transition selector top level: input register, selection and
// lookup logic, result register. Depends on tmts_pkg, tmts_select, tmts_info.
// Results pass through the input register, then the result register.
// Throughput: one item per cycle; a held result stalls input only when both
// registers are full.
// Reset: mode NP, no mission, both registers empty.
module train_mode_transition_selector import tmts_pkg::*; #(
  parameter int NUM_CONDITIONS = NumConditions,
  parameter int NUM_INFO_ITEMS = NumInfoItems
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [63:0]               cond_flags_low_i,
  input  logic [13:0]               cond_flags_high_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [4:0]                new_mode_o,
  output logic                      mode_changed_o,
  output logic [6:0]                winning_condition_o,
  output logic                      mission_done_o,
  output logic                      clear_override_o,
  output logic                      report_position_o,
  output logic                      left_power_up_o,
  output logic [NUM_INFO_ITEMS-1:0] delete_mask_o,
  output logic [NUM_INFO_ITEMS-1:0] invalidate_mask_o
);
  logic                      in_vld_q;
  logic [77:0]               in_q;
  logic [4:0]                mode_q, mode_d;
  logic                      mis_q, mis_d;
  logic [4:0]                dst, prev;
  logic [6:0]                win;
  logic [NUM_INFO_ITEMS-1:0] del, inv;
  logic [NUM_CONDITIONS-1:0] cond;
  logic                      go, out_free, chg, endm;

  assign out_free = !valid_o || ready_i;
  assign go       = in_vld_q && out_free;
  assign ready_o  = !in_vld_q || out_free;

  always_comb begin
    cond = '0;
    for (int i = 0; i < NUM_CONDITIONS; i++) if (i < 78) cond[i] = in_q[i];
  end

  assign prev = (mode_q >= 5'(NumModes)) ? M_NP : mode_q;

  tmts_select #(.NUM_CONDITIONS(NUM_CONDITIONS)) u_sel (
    .cur_mode_i(mode_q), .cond_i(cond), .dst_o(dst), .win_o(win)
  );
  tmts_info #(.NUM_INFO_ITEMS(NUM_INFO_ITEMS)) u_info (
    .prev_i(prev), .dst_i(dst), .del_o(del), .inv_o(inv)
  );

  assign chg = (dst != prev);
  always_comb begin
    endm = 1'b0;
    if (dst == M_SB && (prev == M_FS || prev == M_LS || prev == M_OS || prev == M_UN ||
        prev == M_NL || prev == M_SR || prev == M_PT || prev == M_RV || prev == M_SN))
      endm = 1'b1;
    if (dst == M_SH && (prev == M_FS || prev == M_LS || prev == M_OS || prev == M_SR ||
        prev == M_SN || prev == M_UN))
      endm = 1'b1;
    if (dst == M_SH && prev == M_PT && (mis_q || 1'b0)) endm = 1'b1;
    endm = endm && chg;
    mode_d = chg ? dst : mode_q;
    mis_d = mis_q;
    if (chg && (dst == M_FS || dst == M_LS || dst == M_SR || dst == M_OS ||
        dst == M_NL || dst == M_UN || dst == M_SN)) mis_d = 1'b1;
    if (endm) mis_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      valid_o  <= 1'b0;
      mode_q   <= M_NP;
      mis_q    <= 1'b0;
    end else begin
      if (ready_o) in_vld_q <= valid_i;
      if (out_free) valid_o <= in_vld_q;
      if (go) begin
        mode_q <= mode_d;
        mis_q  <= mis_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) in_q <= {cond_flags_high_i, cond_flags_low_i};
    if (go) begin
      new_mode_o          <= chg ? dst : prev;
      mode_changed_o      <= chg;
      winning_condition_o <= chg ? win : NoCond;
      mission_done_o      <= endm;
      clear_override_o    <= chg && (dst == M_TR || dst == M_LS || dst == M_OS ||
                                     dst == M_SH);
      report_position_o   <= chg && dst != M_NP && dst != M_PS &&
                             !(dst == M_SH && prev == M_PS);
      left_power_up_o     <= chg && prev == M_NP;
      delete_mask_o       <= chg ? del : '0;
      invalidate_mask_o   <= chg ? inv : '0;
    end
  end
endmodule

// ===== dv/train_mode_transition_selector_tb.sv =====
// Testbench for train_mode_transition_selector: a predictor of the mode
// transition and information tables checks every result in order.
// Depends on tmts_pkg and the RTL of the block.
`timescale 1ns / 100ps

module train_mode_transition_selector_tb;
  import tmts_pkg::*;

  typedef struct packed {
    logic [4:0]  mode;
    logic        changed;
    logic [6:0]  win;
    logic        endm;
    logic        clr;
    logic        rpt;
    logic        lpu;
    logic [52:0] del;
    logic [52:0] inv;
  } step_result_t;

  localparam int CycleLimit = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        ready_o;
  logic [63:0] cond_flags_low_i = '0;
  logic [13:0] cond_flags_high_i = '0;
  logic        valid_o;
  logic        ready_i = 1'b0;
  logic [4:0]  new_mode_o;
  logic        mode_changed_o;
  logic [6:0]  winning_condition_o;
  logic        mission_done_o;
  logic        clear_override_o;
  logic        report_position_o;
  logic        left_power_up_o;
  logic [52:0] delete_mask_o;
  logic [52:0] invalidate_mask_o;

  train_mode_transition_selector dut (.*);

  always #5 clk_i = ~clk_i;

  // transition table of the predictor
  logic [4:0]  tr_src[$];
  logic [4:0]  tr_dst[$];
  int          tr_prio[$];
  logic [77:0] tr_conds[$];

  string info_tbl[53] = '{
    "UUUUUUUUUUUUUNNUU", "DUUUUUUUUUUUUNNUU", "DDDDUUDUDDDDUNNDD",
    "DDDDUUDUDDDDUNNDD", "DDDDUUDUDDDDUNNDD", "DDDDUUDUDDDDUNNDD",
    "DDDDUUDUDDDDUNNDD", "DDDDUUDUDDUUUNNUD", "DDDDUUDUDDUUUNNUD",
    "DXUYUUDUYZDUUNNDD", "DDUUUUUUDUUUUNNUU", "DDUUUUDUDDDDUNNDD",
    "DUUUUUUUUUUUUNNUU", "DUUUUUUUUUUUUNNUU", "DDDDDDUDDDDDUNNDD",
    "DDDDUUUUDDUUUNNDD", "DDDDUUDUDDDUUNNDD", "DDDDUUUUDDUUUNNDD",
    "DDDDUUDUDDDDUNNDD", "DDDDUUDUDDDDUNNDD", "RRRRUUUURRUUUNNRU",
    "RRRRUUUURRUUUNNUU", "DDDDUUUUDDUUUNNDU", "DDDDUUUUDDUUUNNDU",
    "DUDDUUUUDUUUUNNDD", "DDDDUUDUDDDDUNNDD", "DDDDUUDUDDDDUNNDD",
    "DDDDUUDDDDDDUNNDD", "TUUUUUUUUUUUUNNUU", "RRRRUURURURUUNNRR",
    "RRRRUURRRRRRRNNRR", "RRRRUURURUUUUNNUR", "DDDDUUDUDDDUUNNDD",
    "DDDDUUDUDDDUUNNDD", "TUUUUUUUUUUUUNNUU", "DTUTUUUUUUUUUNNUU",
    "TUUUUUUUUUUUUNNUU", "TUUUUUUUUUUUUNNUU", "DTUUUUUUDUUUUNNUU",
    "UUUUUUUUUUUUUNNUU", "TUUUUUUUUUUUUNNUU", "DTUUUUUUDUUUUNNUU",
    "DDDDUUDUDDDDUNNDU", "DDDDUUDUDDDDUNNDU", "DDDDDDUUDDDDUNNDD",
    "DDDDUUDUDDDDUNNDD", "DDDDUUDUDDDDUNNDD", "DUUUUUUUUUUUUNNUU",
    "UUUUUUUUUUUUUNNUU", "UUUUUUUUUUUUUNNUU", "UUUUUUUUUUUUUNNUU",
    "UUUUUUUUUUUUUNNUU", "DDDDDUDDDDUDUNNDD"
  };

  logic [4:0]   pred_mode;
  logic         pred_mission;
  step_result_t expected_results[$];
  int           errors = 0;
  int           cycles = 0;
  bit           burst_send = 0;
  bit           burst_recv = 0;

  task automatic add_tr(input mode_e s, input mode_e d, input int p, input int a,
                        input int b = -1, input int c = -1, input int e = -1,
                        input int f = -1, input int g = -1, input int h = -1,
                        input int i = -1, input int j = -1);
    int          list[9];
    logic [77:0] m;
    list = '{a, b, c, e, f, g, h, i, j};
    m = '0;
    foreach (list[k]) if (list[k] >= 0) m[list[k]] = 1'b1;
    tr_src.insert(tr_src.size(), s);
    tr_dst.insert(tr_dst.size(), d);
    tr_prio.insert(tr_prio.size(), p);
    tr_conds.insert(tr_conds.size(), m);
  endtask

  task automatic build_table();
    mode_e all_to_is[16];
    all_to_is = '{M_NP, M_SB, M_PS, M_SH, M_FS, M_LS, M_SR, M_OS, M_SL, M_NL,
                  M_UN, M_TR, M_PT, M_SF, M_SN, M_RV};
    add_tr(M_SB, M_SR, 7, 8, 37); add_tr(M_FS, M_SR, 6, 37); add_tr(M_LS, M_SR, 6, 37);
    add_tr(M_OS, M_SR, 6, 37); add_tr(M_PT, M_SR, 5, 8, 37); add_tr(M_UN, M_SR, 4, 44, 45);
    add_tr(M_SN, M_SR, 4, 44, 45);
    add_tr(M_SB, M_FS, 7, 10); add_tr(M_LS, M_FS, 6, 31, 32); add_tr(M_SR, M_FS, 6, 31, 32);
    add_tr(M_OS, M_FS, 6, 31, 32); add_tr(M_UN, M_FS, 7, 25); add_tr(M_PT, M_FS, 5, 31);
    add_tr(M_SN, M_FS, 7, 25);
    add_tr(M_SB, M_TR, 4, 20); add_tr(M_SH, M_TR, 4, 49, 52, 65);
    add_tr(M_FS, M_TR, 4, 12, 16, 17, 18, 20, 41, 65, 66, 69);
    add_tr(M_LS, M_TR, 4, 12, 16, 17, 18, 20, 41, 65, 66, 69);
    add_tr(M_SR, M_TR, 4, 18, 20, 36, 42, 43, 54, 65);
    add_tr(M_OS, M_TR, 4, 12, 16, 17, 18, 20, 41, 65, 66, 69);
    add_tr(M_UN, M_TR, 5, 20, 39, 67); add_tr(M_SN, M_TR, 5, 20, 35, 38, 39, 67);
    add_tr(M_TR, M_PT, 4, 7);
    add_tr(M_SB, M_UN, 7, 60); add_tr(M_FS, M_UN, 6, 21); add_tr(M_LS, M_UN, 6, 21);
    add_tr(M_SR, M_UN, 6, 21); add_tr(M_OS, M_UN, 6, 21); add_tr(M_TR, M_UN, 4, 62);
    add_tr(M_SN, M_UN, 7, 21);
    add_tr(M_SB, M_SH, 7, 5, 6, 50); add_tr(M_PS, M_SH, 4, 23);
    add_tr(M_FS, M_SH, 6, 5, 6, 50, 51); add_tr(M_LS, M_SH, 6, 5, 6, 50, 51);
    add_tr(M_SR, M_SH, 6, 5, 6, 51); add_tr(M_OS, M_SH, 6, 5, 6, 50, 51);
    add_tr(M_UN, M_SH, 7, 5, 61); add_tr(M_TR, M_SH, 4, 68);
    add_tr(M_PT, M_SH, 5, 5, 6, 50); add_tr(M_SN, M_SH, 7, 5, 61);
    add_tr(M_NP, M_SB, 2, 4); add_tr(M_PS, M_SB, 4, 22); add_tr(M_SH, M_SB, 5, 19, 27, 30);
    add_tr(M_FS, M_SB, 5, 28); add_tr(M_LS, M_SB, 5, 28); add_tr(M_SR, M_SB, 5, 28);
    add_tr(M_OS, M_SB, 5, 28); add_tr(M_SL, M_SB, 3, 2, 3); add_tr(M_NL, M_SB, 3, 28, 47);
    add_tr(M_UN, M_SB, 6, 28); add_tr(M_PT, M_SB, 4, 28); add_tr(M_SN, M_SB, 6, 28);
    add_tr(M_RV, M_SB, 4, 28);
    add_tr(M_SB, M_OS, 7, 15); add_tr(M_FS, M_OS, 6, 15, 40); add_tr(M_LS, M_OS, 6, 15, 73);
    add_tr(M_SR, M_OS, 6, 40); add_tr(M_UN, M_OS, 7, 34); add_tr(M_PT, M_OS, 5, 15);
    add_tr(M_SN, M_OS, 7, 34);
    add_tr(M_SB, M_SL, 5, 14); add_tr(M_PS, M_SL, 4, 14);
    add_tr(M_FS, M_UN, 6, 59); add_tr(M_LS, M_UN, 6, 59); add_tr(M_OS, M_UN, 6, 59);
    add_tr(M_SB, M_SN, 7, 58); add_tr(M_FS, M_SN, 6, 56); add_tr(M_LS, M_SN, 6, 56);
    add_tr(M_SR, M_SN, 6, 56); add_tr(M_OS, M_SN, 6, 56); add_tr(M_UN, M_SN, 7, 56);
    add_tr(M_TR, M_SN, 4, 63);
    add_tr(M_SB, M_LS, 7, 70); add_tr(M_FS, M_LS, 6, 70, 72); add_tr(M_SR, M_LS, 6, 72);
    add_tr(M_OS, M_LS, 6, 70, 74); add_tr(M_UN, M_LS, 7, 71); add_tr(M_PT, M_LS, 5, 70);
    add_tr(M_SN, M_LS, 7, 71);
    foreach (all_to_is[k]) add_tr(all_to_is[k], M_IS, 1, 1);
    add_tr(M_SB, M_NL, 6, 46); add_tr(M_SH, M_NL, 5, 46); add_tr(M_FS, M_NL, 6, 46);
    add_tr(M_LS, M_NL, 6, 46); add_tr(M_SR, M_NL, 6, 46); add_tr(M_OS, M_NL, 6, 46);
    add_tr(M_IS, M_SB, 1, 75);
    foreach (all_to_is[k]) add_tr(all_to_is[k], M_SF, 1, 76);
    add_tr(M_SF, M_SB, 1, 77);
  endtask

  function automatic step_result_t predict_mode_step(input logic [77:0] flags);
    step_result_t r;
    logic [4:0]   prev;
    logic [4:0]   dst;
    logic [77:0]  hit;
    int           best;
    int           win;
    byte          c;
    bit           d;
    prev = pred_mode;
    dst = prev;
    best = NoPrio;
    win = NoCond;
    r = '0;
    foreach (tr_src[t]) begin
      if (tr_src[t] == prev && tr_prio[t] < best) begin
        hit = tr_conds[t] & flags;
        if (hit != '0) begin
          best = tr_prio[t];
          dst = tr_dst[t];
          for (int k = 77; k >= 0; k--) if (hit[k]) win = k;
        end
      end
    end
    if (dst == prev) begin
      r.mode = prev;
      r.win = NoCond;
      return r;
    end
    pred_mode = dst;
    if (dst inside {M_FS, M_LS, M_SR, M_OS, M_NL, M_UN, M_SN}) pred_mission = 1'b1;
    if (dst == M_SB && prev inside {M_FS, M_LS, M_OS, M_UN, M_NL, M_SR, M_PT, M_RV, M_SN})
      r.endm = 1'b1;
    if (dst == M_SH && prev inside {M_FS, M_LS, M_OS, M_SR, M_SN, M_UN}) r.endm = 1'b1;
    if (dst == M_SH && prev == M_PT && pred_mission) r.endm = 1'b1;
    if (r.endm) pred_mission = 1'b0;
    for (int k = 0; k < 53; k++) begin
      c = info_tbl[k][dst];
      case (c)
        "D", "R": d = 1'b1;
        "X":      d = (prev != M_SH && prev != M_PS);
        "Y":      d = (prev != M_PS);
        "Z":      d = (prev != M_SH);
        default:  d = 1'b0;
      endcase
      r.del[k] = d;
      r.inv[k] = (c == "T");
    end
    r.mode = dst;
    r.changed = 1'b1;
    r.win = 7'(win);
    r.clr = dst inside {M_TR, M_LS, M_OS, M_SH};
    r.rpt = (dst != M_NP && dst != M_PS && !(dst == M_SH && prev == M_PS));
    r.lpu = (prev == M_NP);
    return r;
  endfunction

  function automatic int draw_gap(inout bit burst);
    if ($urandom_range(0, 15) == 0) burst = ~burst;
    return burst ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic send_flags(input logic [77:0] flags);
    int gap;
    gap = draw_gap(burst_send);
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    cond_flags_low_i <= flags[63:0];
    cond_flags_high_i <= flags[77:64];
    do @(posedge clk_i); while (!ready_o);
    expected_results.insert(expected_results.size(), predict_mode_step(flags));
  endtask

  task automatic send_cond(input int c);
    logic [77:0] f;
    f = '0;
    f[c] = 1'b1;
    send_flags(f);
  endtask

  initial begin
    int n;
    forever begin
      n = draw_gap(burst_recv);
      if (n > 0) begin
        ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      ready_i <= 1'b1;
      do @(posedge clk_i); while (!valid_o);
    end
  end

  always @(posedge clk_i) begin
    step_result_t e;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[train_mode_transition_selector] ERROR");
      $finish;
    end
    if (rst_ni && valid_o && ready_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (new_mode_o !== e.mode) begin
          $error("new_mode exp %0d got %0d", e.mode, new_mode_o); errors++;
        end
        if (mode_changed_o !== e.changed) begin
          $error("mode_changed exp %0d got %0d", e.changed, mode_changed_o); errors++;
        end
        if (winning_condition_o !== e.win) begin
          $error("winning_condition exp %0d got %0d", e.win, winning_condition_o); errors++;
        end
        if (mission_done_o !== e.endm) begin
          $error("mission_done exp %0d got %0d", e.endm, mission_done_o); errors++;
        end
        if (clear_override_o !== e.clr) begin
          $error("clear_override exp %0d got %0d", e.clr, clear_override_o); errors++;
        end
        if (report_position_o !== e.rpt) begin
          $error("report_position exp %0d got %0d", e.rpt, report_position_o); errors++;
        end
        if (left_power_up_o !== e.lpu) begin
          $error("left_power_up exp %0d got %0d", e.lpu, left_power_up_o); errors++;
        end
        if (delete_mask_o !== e.del) begin
          $error("delete_mask exp %h got %h", e.del, delete_mask_o); errors++;
        end
        if (invalidate_mask_o !== e.inv) begin
          $error("invalidate_mask exp %h got %h", e.inv, invalidate_mask_o); errors++;
        end
      end
    end
  end

  task automatic test_flag_extremes();
    send_flags('0);
    send_cond(0);
    send_flags('1);
    send_cond(1);
    send_cond(75);
    send_flags({14'h3fff, 64'h0});
  endtask

  task automatic test_mode_walk();
    logic [77:0] f;
    send_cond(76);
    send_cond(76);
    f = '0; f[76] = 1'b1; f[77] = 1'b1;
    send_flags(f);
    send_cond(77);
    f = '0; f[37] = 1'b1; f[8] = 1'b1;
    send_flags(f);
    send_cond(31);
    send_cond(50);
    send_cond(46);
    send_cond(47);
    send_cond(10);
    send_cond(12);
    send_cond(7);
    send_cond(5);
    send_cond(19);
    send_cond(14);
    send_cond(3);
  endtask

  task automatic test_random_sequences(input int count);
    logic [77:0] f;
    int          cand[$];
    int          t;
    int          c;
    repeat (count) begin
      f = '0;
      if ($urandom_range(0, 9) < 2) begin
        f = 78'({$urandom(), $urandom(), $urandom()});
        if ($urandom_range(0, 1)) f[76] = 1'b0;
        if ($urandom_range(0, 1)) f[1] = 1'b0;
      end else begin
        cand.delete();
        foreach (tr_src[k])
          if (tr_src[k] == pred_mode && tr_prio[k] > 1) cand.insert(cand.size(), k);
        if (pred_mode == M_IS || pred_mode == M_SF || $urandom_range(0, 19) == 0)
          foreach (tr_src[k]) if (tr_src[k] == pred_mode) cand.insert(cand.size(), k);
        if (cand.size() > 0 && $urandom_range(0, 9) > 0) begin
          t = cand[$urandom_range(0, cand.size() - 1)];
          do c = $urandom_range(0, 77); while (!tr_conds[t][c]);
          f[c] = 1'b1;
        end
        repeat ($urandom_range(0, 3)) f[$urandom_range(0, 77)] = 1'b1;
      end
      send_flags(f);
    end
  endtask

  initial begin
    build_table();
    pred_mode = M_NP;
    pred_mission = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_flag_extremes();
    test_mode_walk();
    test_random_sequences(1200);
    valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("[train_mode_transition_selector] OK");
    end else begin
      $display("[train_mode_transition_selector] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tmts_pkg.sv
rtl/tmts_select.sv
rtl/tmts_info.sv
rtl/train_mode_transition_selector.sv
dv/train_mode_transition_selector_tb.sv
